// ===== src/bpp_pkg.sv =====
// bpp_pkg: shared constants for the derivation path parser
// character codes, result status codes and field widths
// no dependencies
package bpp_pkg;

    localparam int CHAR_W  = 8;
    localparam int INDEX_W = 31;
    localparam int STATUS_W = 2;

    localparam logic [CHAR_W-1:0] CHAR_M     = 8'h6D;  // 'm'
    localparam logic [CHAR_W-1:0] CHAR_SLASH = 8'h2F;  // '/'
    localparam logic [CHAR_W-1:0] CHAR_APOS  = 8'h27;  // apostrophe
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;  // '0'
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;  // '9'

    typedef enum logic [STATUS_W-1:0] {
        STATUS_COMPONENT = 2'd0,
        STATUS_VALID     = 2'd1,
        STATUS_INVALID   = 2'd2
    } status_t;

endpackage

// ===== src/bpp_stream_if.sv =====
// bpp_char_if and bpp_result_if: valid/ready channels of the path parser
// depends on bpp_pkg for field widths and the status type

interface bpp_char_if;
    logic                              valid;
    logic                              ready;
    logic [bpp_pkg::CHAR_W-1:0]        char_code;
    logic                              end_of_path;

    modport source (output valid, output char_code, output end_of_path, input ready);
    modport sink   (input valid, input char_code, input end_of_path, output ready);
endinterface

interface bpp_result_if;
    logic                              valid;
    logic                              ready;
    logic [bpp_pkg::INDEX_W-1:0]       child_index;
    logic                              hardened;
    logic                              has_component;
    bpp_pkg::status_t                  status;

    modport source (output valid, output child_index, output hardened,
                    output has_component, output status, input ready);
    modport sink   (input valid, input child_index, input hardened,
                    input has_component, input status, output ready);
endinterface

// ===== src/bip32_path_parser.sv =====
// bip32_path_parser: streaming parser for hierarchical key derivation paths
// depends on bpp_pkg and the channel interfaces in bpp_stream_if.sv
//
// usage
//   chars   : one transaction per path character (char_code), or a closing
//             transaction with end_of_path set (char_code ignored)
//   results : one transaction per completed component (status component)
//             and exactly one per closing transaction (status valid or
//             invalid, carrying the pending component if there is one)
// timing
//   a character is taken into the parser state and, if it completes a
//   component or closes the path, its result sits in the output register
//   on the next cycle; one character a cycle while the output register
//   is free or being drained; the x10 multiply-add and range check on
//   the 31-bit accumulator are combinational
// reset
//   rst_n clears the parser to "expect m" with no result pending
// stall
//   while the output register holds an untaken result, chars.ready is
//   high only if results.ready is high in the same cycle; otherwise the
//   parser holds its state and waits
// after a syntax error characters are swallowed until the closing transaction

module bip32_path_parser
(
    input  logic               clk,
    input  logic               rst_n,
    bpp_char_if.sink           chars,
    bpp_result_if.source       results
);

    typedef enum logic [2:0] {
        PH_M      = 3'd0,
        PH_SLASH  = 3'd1,
        PH_START  = 3'd2,
        PH_DIGITS = 3'd3,
        PH_HARD   = 3'd4
    } phase_t;

    localparam int PROD_W = bpp_pkg::INDEX_W + 4;

    phase_t                      phase_reg,       phase_next;
    logic [bpp_pkg::INDEX_W-1:0] acc_reg,         acc_next;
    logic                        lead_zero_reg,   lead_zero_next;
    logic                        hard_seen_reg,   hard_seen_next;
    logic                        error_reg,       error_next;

    logic                        out_valid_reg,   out_valid_next;
    logic [bpp_pkg::INDEX_W-1:0] out_index_reg,   out_index_next;
    logic                        out_hard_reg,    out_hard_next;
    logic                        out_has_reg,     out_has_next;
    bpp_pkg::status_t            out_status_reg,  out_status_next;

    logic                        accept;
    logic                        is_digit;
    logic [3:0]                  digit;
    logic [PROD_W-1:0]           acc_prod;
    logic                        overflow;
    logic                        valid_end;
    logic                        pending;

    // output register frees up when it is empty or being drained
    assign chars.ready = !out_valid_reg || results.ready;
    assign accept      = chars.valid && chars.ready;

    assign is_digit = (chars.char_code >= bpp_pkg::CHAR_ZERO)
                   && (chars.char_code <= bpp_pkg::CHAR_NINE);
    assign digit    = 4'(chars.char_code - bpp_pkg::CHAR_ZERO);

    // acc * 10 + digit, as acc*8 + acc*2 + digit
    assign acc_prod = (PROD_W'(acc_reg) << 3) + (PROD_W'(acc_reg) << 1) + PROD_W'(digit);
    assign overflow = |acc_prod[PROD_W-1:bpp_pkg::INDEX_W];

    assign valid_end = !error_reg && (phase_reg != PH_M) && (phase_reg != PH_SLASH);
    assign pending   = valid_end && ((phase_reg == PH_DIGITS) || (phase_reg == PH_HARD));

    always_comb
    begin
        phase_next      = phase_reg;
        acc_next        = acc_reg;
        lead_zero_next  = lead_zero_reg;
        hard_seen_next  = hard_seen_reg;
        error_next      = error_reg;

        out_valid_next  = out_valid_reg && !results.ready;
        out_index_next  = out_index_reg;
        out_hard_next   = out_hard_reg;
        out_has_next    = out_has_reg;
        out_status_next = out_status_reg;

        if (accept)
        begin
            if (chars.end_of_path)
            begin
                // closing transaction: report status, then back to reset state
                out_valid_next  = 1'b1;
                out_has_next    = pending;
                out_index_next  = pending ? acc_reg : '0;
                out_hard_next   = pending && hard_seen_reg;
                out_status_next = valid_end ? bpp_pkg::STATUS_VALID
                                            : bpp_pkg::STATUS_INVALID;
                phase_next      = PH_M;
                acc_next        = '0;
                lead_zero_next  = 1'b0;
                hard_seen_next  = 1'b0;
                error_next      = 1'b0;
            end
            else if (!error_reg)
            begin
                unique case (phase_reg)
                    PH_M:
                    begin
                        if (chars.char_code == bpp_pkg::CHAR_M)
                            phase_next = PH_SLASH;
                        else
                            error_next = 1'b1;
                    end
                    PH_SLASH:
                    begin
                        if (chars.char_code == bpp_pkg::CHAR_SLASH)
                            phase_next = PH_START;
                        else
                            error_next = 1'b1;
                    end
                    PH_START:
                    begin
                        // repeated slashes give empty components, skipped
                        if (chars.char_code == bpp_pkg::CHAR_SLASH)
                            phase_next = PH_START;
                        else if (is_digit)
                        begin
                            acc_next       = bpp_pkg::INDEX_W'(digit);
                            lead_zero_next = (digit == 4'd0);
                            phase_next     = PH_DIGITS;
                        end
                        else
                            error_next = 1'b1;
                    end
                    PH_DIGITS, PH_HARD:
                    begin
                        if (chars.char_code == bpp_pkg::CHAR_SLASH)
                        begin
                            out_valid_next  = 1'b1;
                            out_has_next    = 1'b1;
                            out_index_next  = acc_reg;
                            out_hard_next   = (phase_reg == PH_HARD);
                            out_status_next = bpp_pkg::STATUS_COMPONENT;
                            acc_next        = '0;
                            lead_zero_next  = 1'b0;
                            hard_seen_next  = 1'b0;
                            phase_next      = PH_START;
                        end
                        else if (phase_reg == PH_HARD)
                            error_next = 1'b1;
                        else if (chars.char_code == bpp_pkg::CHAR_APOS)
                        begin
                            hard_seen_next = 1'b1;
                            phase_next     = PH_HARD;
                        end
                        else if (is_digit && !lead_zero_reg && !overflow)
                            acc_next = acc_prod[bpp_pkg::INDEX_W-1:0];
                        else
                            error_next = 1'b1;
                    end
                    default:
                        error_next = 1'b1;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_M;
            acc_reg        <= '0;
            lead_zero_reg  <= 1'b0;
            hard_seen_reg  <= 1'b0;
            error_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_index_reg  <= '0;
            out_hard_reg   <= 1'b0;
            out_has_reg    <= 1'b0;
            out_status_reg <= bpp_pkg::STATUS_COMPONENT;
        end
        else
        begin
            phase_reg      <= phase_next;
            acc_reg        <= acc_next;
            lead_zero_reg  <= lead_zero_next;
            hard_seen_reg  <= hard_seen_next;
            error_reg      <= error_next;
            out_valid_reg  <= out_valid_next;
            out_index_reg  <= out_index_next;
            out_hard_reg   <= out_hard_next;
            out_has_reg    <= out_has_next;
            out_status_reg <= out_status_next;
        end
    end

    assign results.valid         = out_valid_reg;
    assign results.child_index   = out_index_reg;
    assign results.hardened      = out_hard_reg;
    assign results.has_component = out_has_reg;
    assign results.status        = out_status_reg;

    // a closing transaction always leaves a result in the output register
    a_end_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept && chars.end_of_path |=> out_valid_reg && out_status_reg != bpp_pkg::STATUS_COMPONENT)
        else $error("closing transaction produced no status result");

    // a mid-path result always carries a component
    a_component_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_status_reg == bpp_pkg::STATUS_COMPONENT |-> out_has_reg)
        else $error("component result without has_component");

    // fields are zero when no component is carried
    a_empty_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_has_reg |-> out_index_reg == '0 && !out_hard_reg)
        else $error("empty result carries non-zero fields");

    // once an error is flagged, characters make no further results
    a_error_silent: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !chars.end_of_path && error_reg |=> !out_valid_reg || $stable(out_index_reg)
            && $stable(out_status_reg) && $stable(out_has_reg))
        else $error("result produced after a syntax error");

endmodule
